>>> sv/dlsf_pkg.sv
// Shared types and constants of the dual light sensor fusion average unit.
// Used by the top level and its port checker; depends on nothing.
`default_nettype none

package dlsf_pkg;

	// Field widths of the stream beats.
	localparam int SAMPLE_W    = 10;
	localparam int LEVEL_W     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 5;

	// Default ring length exponent.
	localparam int LOG2_DEPTH_DEF = 4;

	// Scaling maps raw 1..1022 onto min..max, so the divisor is 1021.
	// The quotient is estimated as (x * 1027) >> 20 and corrected once.
	localparam int RAW_SPAN    = 1021;
	localparam int RECIP       = 1027;
	localparam int RECIP_SHIFT = 20;
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 8'd255;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_A        = 3'd0,
		REG_ENABLE_B        = 3'd1,
		REG_OUT_MIN_A       = 3'd2,
		REG_OUT_MAX_A       = 3'd3,
		REG_OUT_MIN_B       = 3'd4,
		REG_OUT_MAX_B       = 3'd5,
		REG_DISPARITY_LIMIT = 3'd6
	} cfg_reg_t;

	// How the fused level was formed.
	typedef enum logic [2:0] {
		MODE_MEAN     = 3'd0,
		MODE_HIGHER   = 3'd1,
		MODE_A_ONLY   = 3'd2,
		MODE_B_ONLY   = 3'd3,
		MODE_BOTH_BAD = 3'd4
	} fusion_mode_t;

	// One finished result waiting in the output buffer.
	typedef struct packed {
		logic [LEVEL_W-1:0] level_avg;
		logic [LEVEL_W-1:0] level_now;
		logic               fault_a;
		logic               fault_b;
		fusion_mode_t       fusion_mode;
	} result_t;

endpackage

`default_nettype wire

>>> sv/dlsf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Holds the history ring of the fusion average unit; no package dependency.
`default_nettype none

module dlsf_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/dual_light_sensor_fusion_average_unit.sv
// Top level of the dual light sensor fusion average unit.
// Depends on dlsf_pkg and instantiates dlsf_ram for the history ring.
//
// Usage:
// Input beats arrive on s_tvalid/s_tready/s_tdata, each carrying one raw 10-bit sample
// per sensor. Each accepted beat yields exactly one output beat on m_tvalid/m_tready
// with the moving average and the fused level in m_tdata and the fault flags and the
// fusion mode in m_tuser. Configuration registers are written over cfg_valid/cfg_index/
// cfg_data; cfg_ready is always high and writes belong to idle periods.
// Path: a beat passes five arithmetic stages and the ring read stage, then enters the
// output buffer that drives m_tvalid.
// Throughput: one beat per cycle while the receiver takes results; the stage pipeline
// keeps filling while the receiver stalls, and a two-entry output buffer keeps the RAM
// read and write back in lock step, so a stall never drops or repeats a result.
// Reset: the control, pointer, sum, configuration and stage 4 registers take their reset
// values at once; the other data registers have none. The history ring needs no clearing
// pass: until the write slot wraps for the first time, every read of the ring is taken as zero.
// Ring access: each beat reads and rewrites the slot after the previous beat's slot,
// so the write back of one beat never meets the read of the next one.
`default_nettype none

module dual_light_sensor_fusion_average_unit #(
	parameter int LOG2_DEPTH = dlsf_pkg::LOG2_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input stream.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [dlsf_pkg::IN_TDATA_W-1:0]  s_tdata,   // sample_a[9:0], sample_b[19:10]
	// Output stream.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [dlsf_pkg::OUT_TDATA_W-1:0]      m_tdata,   // level_avg[7:0], level_now[15:8]
	output logic [dlsf_pkg::OUT_TUSER_W-1:0]      m_tuser,   // fault_a[0], fault_b[1],
	                                                         // fusion_mode[4:2]
	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dlsf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dlsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SUM_W = LOG2_DEPTH + dlsf_pkg::LEVEL_W;
	localparam int LW    = dlsf_pkg::LEVEL_W;

	// ------------------------------------------------------------------
	// Configuration registers.
	logic          enable_a_q, enable_b_q;
	logic [LW-1:0] out_min_a_q, out_max_a_q, out_min_b_q, out_max_b_q;
	logic [LW-1:0] disparity_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_a_q        <= 1'b1;
			enable_b_q        <= 1'b1;
			out_min_a_q       <= '0;
			out_max_a_q       <= dlsf_pkg::LEVEL_TOP;
			out_min_b_q       <= '0;
			out_max_b_q       <= dlsf_pkg::LEVEL_TOP;
			disparity_limit_q <= 8'd32;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dlsf_pkg::REG_ENABLE_A:        enable_a_q        <= cfg_data[0];
				dlsf_pkg::REG_ENABLE_B:        enable_b_q        <= cfg_data[0];
				dlsf_pkg::REG_OUT_MIN_A:       out_min_a_q       <= cfg_data;
				dlsf_pkg::REG_OUT_MAX_A:       out_max_a_q       <= cfg_data;
				dlsf_pkg::REG_OUT_MIN_B:       out_min_b_q       <= cfg_data;
				dlsf_pkg::REG_OUT_MAX_B:       out_max_b_q       <= cfg_data;
				dlsf_pkg::REG_DISPARITY_LIMIT: disparity_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-lane views of the configuration (lane 0 is sensor A, lane 1 is sensor B).
	logic [LW-1:0] lo [2];
	logic [LW-1:0] hi [2];
	logic          en [2];
	logic [dlsf_pkg::SAMPLE_W-1:0] smp [2];

	assign lo[0]  = out_min_a_q;
	assign lo[1]  = out_min_b_q;
	assign hi[0]  = out_max_a_q;
	assign hi[1]  = out_max_b_q;
	assign en[0]  = enable_a_q;
	assign en[1]  = enable_b_q;
	assign smp[0] = s_tdata[9:0];
	assign smp[1] = s_tdata[19:10];

	// ------------------------------------------------------------------
	// Pipeline flow control: each stage loads when it is empty or moving on.
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic take1, take2, take3, take4, take5;
	logic issue, issue_ok, accept;

	assign issue    = v5_q && issue_ok;
	assign take5    = !v5_q || issue;
	assign take4    = !v4_q || take5;
	assign take3    = !v3_q || take4;
	assign take2    = !v2_q || take3;
	assign take1    = !v1_q || take2;
	assign s_tready = take1;
	assign accept   = s_tvalid && take1;

	// ------------------------------------------------------------------
	// Stage 1: offset sample times span, kept as magnitude and sign.
	logic signed [10:0] num  [2];
	logic signed [8:0]  span [2];
	logic signed [19:0] prod [2];
	logic signed [19:0] negp [2];
	logic [17:0]        mag_s1 [2];
	logic               neg_s1 [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			num[i]  = $signed({1'b0, smp[i]}) - 11'sd1;
			span[i] = $signed({1'b0, hi[i]}) - $signed({1'b0, lo[i]});
			prod[i] = 20'(num[i]) * 20'(span[i]);
			negp[i] = -prod[i];
		end
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			for (int i = 0; i < 2; i++) begin
				mag_s1[i] <= prod[i][19] ? negp[i][17:0] : prod[i][17:0];
				neg_s1[i] <= prod[i][19];
			end
		end
	end

	// Stage 2: quotient estimate by reciprocal multiply, low by at most one.
	logic [28:0] est   [2];
	logic [7:0]  q0_s2 [2];
	logic [17:0] mag_s2 [2];
	logic        neg_s2 [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			est[i] = 29'(mag_s1[i]) * 29'(dlsf_pkg::RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (take2) begin
			for (int i = 0; i < 2; i++) begin
				q0_s2[i]  <= est[i][dlsf_pkg::RECIP_SHIFT +: 8];
				mag_s2[i] <= mag_s1[i];
				neg_s2[i] <= neg_s1[i];
			end
		end
	end

	// Stage 3: correct the estimate and restore the sign (truncation toward zero).
	logic [17:0]       qm  [2];
	logic [17:0]       rem [2];
	logic [7:0]        qc  [2];
	logic signed [8:0] qs_s3 [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qm[i]  = 18'(q0_s2[i]) * 18'(dlsf_pkg::RAW_SPAN);
			rem[i] = mag_s2[i] - qm[i];
			qc[i]  = q0_s2[i] + ((rem[i] >= 18'(dlsf_pkg::RAW_SPAN)) ? 8'd1 : 8'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (take3) begin
			for (int i = 0; i < 2; i++) begin
				qs_s3[i] <= neg_s2[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
			end
		end
	end

	// Stage 4: add the lower end, clamp, flag bad connections. A disabled sensor
	// keeps its reading; the held readings are this stage's payload.
	logic signed [10:0] vsum [2];
	logic [LW-1:0]      clamped [2];
	logic [LW-1:0]      reading_q [2];
	logic               bad_q [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			vsum[i] = 11'(qs_s3[i]) + $signed({3'b000, lo[i]});
			if (vsum[i] < 0) begin
				clamped[i] = '0;
			end else if (vsum[i] > $signed({3'b000, dlsf_pkg::LEVEL_TOP})) begin
				clamped[i] = dlsf_pkg::LEVEL_TOP;
			end else begin
				clamped[i] = vsum[i][LW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				reading_q[i] <= '0;
				bad_q[i]     <= 1'b0;
			end
		end else if (v3_q && take4) begin
			for (int i = 0; i < 2; i++) begin
				if (en[i]) begin
					reading_q[i] <= clamped[i];
					bad_q[i]     <= (clamped[i] == '0) || (clamped[i] == dlsf_pkg::LEVEL_TOP);
				end
			end
		end
	end

	// Stage 5: fuse the two readings.
	logic [LW-1:0]          diff, higher;
	logic [LW:0]            pair_sum;
	logic [LW-1:0]          fused;
	dlsf_pkg::fusion_mode_t mode;
	logic [LW-1:0]          fused_s5;
	dlsf_pkg::fusion_mode_t mode_s5;
	logic                   fault_a_s5, fault_b_s5;

	always_comb begin
		diff     = (reading_q[0] > reading_q[1]) ? reading_q[0] - reading_q[1]
		                                         : reading_q[1] - reading_q[0];
		higher   = (reading_q[0] > reading_q[1]) ? reading_q[0] : reading_q[1];
		pair_sum = {1'b0, reading_q[0]} + {1'b0, reading_q[1]};
		if (!bad_q[0] && !bad_q[1]) begin
			if (diff >= disparity_limit_q) begin
				fused = higher;
				mode  = dlsf_pkg::MODE_HIGHER;
			end else begin
				fused = pair_sum[LW:1];
				mode  = dlsf_pkg::MODE_MEAN;
			end
		end else if (!bad_q[0]) begin
			fused = reading_q[0];
			mode  = dlsf_pkg::MODE_A_ONLY;
		end else if (!bad_q[1]) begin
			fused = reading_q[1];
			mode  = dlsf_pkg::MODE_B_ONLY;
		end else begin
			fused = dlsf_pkg::LEVEL_TOP;
			mode  = dlsf_pkg::MODE_BOTH_BAD;
		end
	end

	always_ff @(posedge clk) begin
		if (take5) begin
			fused_s5   <= fused;
			mode_s5    <= mode;
			fault_a_s5 <= bad_q[0];
			fault_b_s5 <= bad_q[1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: ring read issued, write back and running sum in the following cycle.
	logic [LOG2_DEPTH-1:0]  slot_q;
	logic                   wrapped_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   v6_q;
	logic [LOG2_DEPTH-1:0]  slot_s6;
	logic                   old_ok_s6;
	logic [LW-1:0]          fused_s6;
	dlsf_pkg::fusion_mode_t mode_s6;
	logic                   fault_a_s6, fault_b_s6;
	logic [LW-1:0]          ram_rdata, old_level;
	logic [SUM_W-1:0]       sum_next;

	dlsf_ram #(
		.WIDTH  (LW),
		.ADDR_W (LOG2_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (v6_q),
		.waddr (slot_s6),
		.wdata (fused_s6),
		.re    (issue),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// Entries not yet written since reset read as zero.
	assign old_level = old_ok_s6 ? ram_rdata : '0;
	assign sum_next  = sum_q - SUM_W'(old_level) + SUM_W'(fused_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else begin
			if (issue) begin
				slot_q <= slot_q + LOG2_DEPTH'(1);
				if (slot_q == {LOG2_DEPTH{1'b1}}) begin
					wrapped_q <= 1'b1;
				end
			end
			if (v6_q) begin
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			slot_s6    <= slot_q;
			old_ok_s6  <= wrapped_q;
			fused_s6   <= fused_s5;
			mode_s6    <= mode_s5;
			fault_a_s6 <= fault_a_s5;
			fault_b_s6 <= fault_b_s5;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
		end else begin
			if (take1) v1_q <= accept;
			if (take2) v2_q <= v1_q;
			if (take3) v3_q <= v2_q;
			if (take4) v4_q <= v3_q;
			if (take5) v5_q <= v4_q;
			v6_q <= issue;
		end
	end

	// ------------------------------------------------------------------
	// Two-entry output buffer. A read is issued only when the buffer will have
	// room for its result, counting the beat already in the write-back cycle.
	dlsf_pkg::result_t obuf_q [2];
	dlsf_pkg::result_t head;
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q, occ;
	logic              pop;

	assign head     = obuf_q[rd_ptr_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign occ      = cnt_q + {1'b0, v6_q};
	assign issue_ok = (occ < 2'd2) || ((occ == 2'd2) && pop);

	assign m_tdata  = {head.level_now, head.level_avg};
	assign m_tuser  = {head.fusion_mode, head.fault_b, head.fault_a};

	always_ff @(posedge clk) begin
		if (v6_q) begin
			obuf_q[wr_ptr_q] <= '{
				level_avg:   sum_next[LOG2_DEPTH +: LW],
				level_now:   fused_s6,
				fault_a:     fault_a_s6,
				fault_b:     fault_b_s6,
				fusion_mode: mode_s6
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (v6_q) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, v6_q} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

>>> sv/dlsf_checker.sv
// Port checker of the dual light sensor fusion average unit, bound to its top level.
// Depends on dlsf_pkg for the stream widths, the full-scale level and the fusion mode codes.
`default_nettype none

module dlsf_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [dlsf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic [dlsf_pkg::OUT_TUSER_W-1:0] m_tuser
);

	// An offered output beat stays until it is taken.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat withdrawn before it was taken");

	// A stalled output beat keeps its contents.
	a_beat_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

	// With both sensors bad the fused level is full scale and both faults show.
	a_both_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[4:2] == dlsf_pkg::MODE_BOTH_BAD)
		|-> (m_tdata[15:8] == dlsf_pkg::LEVEL_TOP) && m_tuser[0] && m_tuser[1])
		else $error("both-bad mode without full-scale level and both faults");

	// Mean and higher-reading modes are used only when both sensors are good.
	a_both_good: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser[4:2] == dlsf_pkg::MODE_MEAN) ||
		             (m_tuser[4:2] == dlsf_pkg::MODE_HIGHER))
		|-> !m_tuser[0] && !m_tuser[1])
		else $error("two-sensor fusion mode while a sensor is flagged");

endmodule

bind dual_light_sensor_fusion_average_unit dlsf_checker u_dlsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
